@@ hw/rtl/dlra_pkg.sv @@
package dlra_pkg;

   // Default sizes of the layer.
   localparam int MAX_INPUTS_DEF  = 1024;
   localparam int MAX_NEURONS_DEF = 64;

   // Field and datapath widths.
   localparam int VAL_W      = 32;
   localparam int ACC_W      = 64;
   localparam int FRAC_W     = 16;
   localparam int ACT_W      = 2;
   localparam int IIDX_W     = 10;
   localparam int NIDX_W     = 6;
   localparam int CNT_IN_W   = 11;
   localparam int CNT_NEU_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Request action codes.
   localparam logic [ACT_W-1:0] ACT_WEIGHT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BIAS   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FEED   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INPUTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEURONS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU    = 2'd2;

   // Configuration reset values.
   localparam logic [CNT_IN_W-1:0]  INPUTS_RST  = 11'd1024;
   localparam logic [CNT_NEU_W-1:0] NEURONS_RST = 7'd64;

   // Control tag that travels with one neuron step down the pipeline.
   typedef struct packed {
      logic              valid;
      logic              in_use;
      logic              first;
      logic              final_vec;
      logic              emit_last;
      logic [NIDX_W-1:0] neuron;
   } tag_type;

endpackage

@@ hw/rtl/dlra_cell.sv @@
module dlra_cell
   import dlra_pkg::*;
(
   input  logic                    clock,
   input  logic                    shift,
   input  logic signed [ACC_W-1:0] d,
   output logic signed [ACC_W-1:0] q
);

   logic signed [ACC_W-1:0] acc_ff;

   // One accumulator of the ring; it takes its d input (the next cell, or the sum at the tail) on every shift.
   always_ff @(posedge clock) begin
      if (shift) begin
         acc_ff <= d;
      end
   end

   assign q = acc_ff;

endmodule

@@ hw/rtl/dlra_mac.sv @@
module dlra_mac
   import dlra_pkg::*;
#(
   parameter int ROW_W = 10,
   parameter int COL_W = 6
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    w_wr_en,
   input  logic                    b_wr_en,
   input  logic [ROW_W-1:0]        wr_row,
   input  logic [COL_W-1:0]        wr_col,
   input  logic signed [VAL_W-1:0] wr_data,
   input  tag_type                 rd_tag,
   input  logic [ROW_W-1:0]        rd_row,
   input  logic [COL_W-1:0]        rd_col,
   input  logic signed [VAL_W-1:0] sample,
   input  logic signed [ACC_W-1:0] head,
   output tag_type                 tag_s2,
   output logic signed [ACC_W-1:0] sum,
   output logic                    pipe_busy
);

   localparam int W_DEPTH = 2 ** (ROW_W + COL_W);
   localparam int B_DEPTH = 2 ** COL_W;

   logic signed [VAL_W-1:0]   weight_mem [W_DEPTH];
   logic signed [VAL_W-1:0]   bias_mem   [B_DEPTH];
   logic signed [VAL_W-1:0]   weight_rd_ff;
   logic signed [VAL_W-1:0]   bias_rd_ff;
   logic signed [VAL_W-1:0]   bias2_ff;
   logic signed [2*VAL_W-1:0] prod_ff;
   tag_type                   tag1_ff;
   tag_type                   tag2_ff;
   logic signed [ACC_W-1:0]   prod_q;
   logic signed [ACC_W-1:0]   base;
   logic signed [ACC_W-1:0]   addend;

   // Store writes.
   always_ff @(posedge clock) begin
      if (w_wr_en) begin
         weight_mem[{wr_row, wr_col}] <= wr_data;
      end
      if (b_wr_en) begin
         bias_mem[wr_col] <= wr_data;
      end
   end

   // Registered store reads, then the registered product.
   always_ff @(posedge clock) begin
      weight_rd_ff <= weight_mem[{rd_row, rd_col}];
      bias_rd_ff   <= bias_mem[rd_col];
      prod_ff      <= sample * weight_rd_ff;
      bias2_ff     <= bias_rd_ff;
   end

   // Control tags follow the data through both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= rd_tag;
         tag2_ff <= tag1_ff;
      end
   end

   // Floor the Q32.32 product to Q48.16 and add it to the head accumulator,
   // or to the bias on the first element of a vector.
   always_comb begin
      prod_q = ACC_W'(prod_ff >>> FRAC_W);
      base   = tag2_ff.first ? ACC_W'(bias2_ff) : head;
      addend = tag2_ff.in_use ? prod_q : '0;
      sum    = base + addend;
   end

   assign tag_s2    = tag2_ff;
   assign pipe_busy = tag1_ff.valid | tag2_ff.valid;

endmodule

@@ hw/rtl/dlra_emit.sv @@
module dlra_emit
   import dlra_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  tag_type                 tag,
   input  logic signed [ACC_W-1:0] acc,
   input  logic                    relu_en,
   output logic                    rsp_valid,
   output logic [NIDX_W-1:0]       rsp_out_neuron,
   output logic signed [VAL_W-1:0] rsp_activation,
   output logic [NIDX_W-1:0]       rsp_best_index,
   output logic                    rsp_last
);

   localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   logic [ACC_W-VAL_W:0]    acc_hi;
   logic                    in_range;
   logic signed [VAL_W-1:0] sat_val;
   logic signed [VAL_W-1:0] act;
   logic                    take;
   logic                    emit;
   logic signed [VAL_W-1:0] best_val_ff;
   logic [NIDX_W-1:0]       best_idx_ff;
   logic signed [VAL_W-1:0] best_val_in;
   logic [NIDX_W-1:0]       best_idx_in;
   logic                    rsp_valid_ff;
   logic [NIDX_W-1:0]       rsp_neuron_ff;
   logic signed [VAL_W-1:0] rsp_act_ff;
   logic [NIDX_W-1:0]       rsp_best_ff;
   logic                    rsp_last_ff;

   // Saturate to 32 bits, apply ReLU when enabled, and track the first strictly greatest value.
   always_comb begin
      acc_hi   = acc[ACC_W-1:VAL_W-1];
      in_range = (&acc_hi) | ~(|acc_hi);
      if (in_range) begin
         sat_val = acc[VAL_W-1:0];
      end else if (acc[ACC_W-1]) begin
         sat_val = SAT_MIN;
      end else begin
         sat_val = SAT_MAX;
      end
      if (relu_en && (sat_val[VAL_W-1] || (sat_val == '0))) begin
         act = '0;
      end else begin
         act = sat_val;
      end
      take        = (tag.neuron == '0) || (act > best_val_ff);
      best_val_in = take ? act : best_val_ff;
      best_idx_in = take ? tag.neuron : best_idx_ff;
      emit        = tag.valid & tag.in_use & tag.final_vec;
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
   end

   // Result payload and running argmax.
   always_ff @(posedge clock) begin
      if (emit) begin
         best_val_ff   <= best_val_in;
         best_idx_ff   <= best_idx_in;
         rsp_neuron_ff <= tag.neuron;
         rsp_act_ff    <= act;
         rsp_best_ff   <= tag.emit_last ? best_idx_in : '0;
         rsp_last_ff   <= tag.emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_neuron = rsp_neuron_ff;
   assign rsp_activation = rsp_act_ff;
   assign rsp_best_index = rsp_best_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ hw/rtl/dense_layer_relu_argmax_core.sv @@
// A feed transfer that completes a vector strobes its results one per cycle in neuron order;
// each passes the sequencer, store read, product, tail cell and result registers in turn.
// A feed transfer holds busy until its pass over all MAX_NEURONS neurons has drained, so no
// new element is taken before the last one is through; the shared multiply-accumulate unit
// visits one neuron per cycle. The receiver cannot stall.
// Reset clears control and loads the configuration defaults; the stores keep their contents, no clearing pass.
module dense_layer_relu_argmax_core
   import dlra_pkg::*;
#(
   parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
   parameter int MAX_NEURONS = MAX_NEURONS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ACT_W-1:0]        req_action,
   input  logic [IIDX_W-1:0]       req_input_index,
   input  logic [NIDX_W-1:0]       req_neuron_index,
   input  logic signed [VAL_W-1:0] req_sample_value,
   output logic                    rsp_valid,
   output logic [NIDX_W-1:0]       rsp_out_neuron,
   output logic signed [VAL_W-1:0] rsp_activation,
   output logic [NIDX_W-1:0]       rsp_best_index,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IB = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int NB = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int EW = ($clog2(MAX_INPUTS + 1) > CNT_IN_W) ? $clog2(MAX_INPUTS + 1) : CNT_IN_W;

   logic [CNT_IN_W-1:0]     cfg_inputs_ff;
   logic [CNT_NEU_W-1:0]    cfg_neurons_ff;
   logic                    cfg_relu_ff;
   logic                    active_ff;
   logic [IB-1:0]           elem_ff;
   logic [IB-1:0]           elem_in;
   logic [IB-1:0]           row_ff;
   logic [CNT_NEU_W-1:0]    n_ff;
   logic signed [VAL_W-1:0] x_ff;
   logic                    first_ff;
   logic                    final_ff;
   logic                    final_in;
   tag_type                 tag3_ff;
   logic [EW-1:0]           i_used;
   logic [EW-1:0]           next_count;
   logic [CNT_NEU_W-1:0]    n_used;
   logic                    n_last;
   logic                    accept;
   logic                    feed_accept;
   logic                    w_wr_en;
   logic                    b_wr_en;
   logic                    pipe_busy;
   tag_type                 rd_tag;
   tag_type                 tag_s2;
   logic signed [ACC_W-1:0] sum;
   logic signed [ACC_W-1:0] cell_q [MAX_NEURONS];
   logic signed [ACC_W-1:0] cell_d [MAX_NEURONS];

   // Effective counts: zero acts as one, values above the maximum act as the maximum.
   always_comb begin
      if (cfg_inputs_ff == '0) begin
         i_used = EW'(1);
      end else if (EW'(cfg_inputs_ff) > EW'(MAX_INPUTS)) begin
         i_used = EW'(MAX_INPUTS);
      end else begin
         i_used = EW'(cfg_inputs_ff);
      end
      if (cfg_neurons_ff == '0) begin
         n_used = CNT_NEU_W'(1);
      end else if (cfg_neurons_ff > CNT_NEU_W'(MAX_NEURONS)) begin
         n_used = CNT_NEU_W'(MAX_NEURONS);
      end else begin
         n_used = cfg_neurons_ff;
      end
   end

   // Request decode and element counting.
   always_comb begin
      accept      = start & ~busy;
      feed_accept = accept && (req_action == ACT_FEED);
      w_wr_en     = accept && (req_action == ACT_WEIGHT) &&
                    (int'(req_input_index) < MAX_INPUTS) &&
                    (int'(req_neuron_index) < MAX_NEURONS);
      b_wr_en     = accept && (req_action == ACT_BIAS) &&
                    (int'(req_neuron_index) < MAX_NEURONS);
      next_count  = EW'(elem_ff) + EW'(1);
      final_in    = next_count >= i_used;
      elem_in     = final_in ? '0 : IB'(next_count);
      n_last      = n_ff == CNT_NEU_W'(MAX_NEURONS - 1);
   end

   // Tag for the neuron being issued this cycle.
   always_comb begin
      rd_tag.valid     = active_ff;
      rd_tag.in_use    = n_ff < n_used;
      rd_tag.first     = first_ff;
      rd_tag.final_vec = final_ff;
      rd_tag.emit_last = n_ff == (n_used - CNT_NEU_W'(1));
      rd_tag.neuron    = n_ff[NIDX_W-1:0];
   end

   // Configuration, element count and sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_inputs_ff  <= INPUTS_RST;
         cfg_neurons_ff <= NEURONS_RST;
         cfg_relu_ff    <= 1'b1;
         active_ff      <= 1'b0;
         elem_ff        <= '0;
         tag3_ff        <= '0;
      end else begin
         tag3_ff <= tag_s2;
         if (csr_valid) begin
            case (csr_index)
               CSR_INPUTS:  cfg_inputs_ff  <= csr_wdata[CNT_IN_W-1:0];
               CSR_NEURONS: cfg_neurons_ff <= csr_wdata[CNT_NEU_W-1:0];
               CSR_RELU:    cfg_relu_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (feed_accept) begin
            active_ff <= 1'b1;
            elem_ff   <= elem_in;
         end else if (active_ff && n_last) begin
            active_ff <= 1'b0;
         end
      end
   end

   // Element payload and neuron counter for the pass.
   always_ff @(posedge clock) begin
      if (feed_accept) begin
         n_ff     <= '0;
         x_ff     <= req_sample_value;
         first_ff <= (elem_ff == '0);
         final_ff <= final_in;
         row_ff   <= elem_ff;
      end else if (active_ff) begin
         n_ff <= n_ff + CNT_NEU_W'(1);
      end
   end

   // Shared multiply-accumulate unit with the weight and bias stores.
   dlra_mac #(
      .ROW_W (IB),
      .COL_W (NB)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .w_wr_en   (w_wr_en),
      .b_wr_en   (b_wr_en),
      .wr_row    (IB'(req_input_index)),
      .wr_col    (NB'(req_neuron_index)),
      .wr_data   (req_sample_value),
      .rd_tag    (rd_tag),
      .rd_row    (row_ff),
      .rd_col    (n_ff[NB-1:0]),
      .sample    (x_ff),
      .head      (cell_q[0]),
      .tag_s2    (tag_s2),
      .sum       (sum),
      .pipe_busy (pipe_busy)
   );

   // Ring of accumulator cells: the head feeds the adder, the sum enters at the tail.
   for (genvar i = 0; i < MAX_NEURONS; i++) begin : g_cell
      if (i == MAX_NEURONS - 1) begin : g_tail
         assign cell_d[i] = sum;
      end else begin : g_body
         assign cell_d[i] = cell_q[i+1];
      end
      dlra_cell u_cell (
         .clock (clock),
         .shift (tag_s2.valid),
         .d     (cell_d[i]),
         .q     (cell_q[i])
      );
   end

   // Activation, ReLU and argmax on the value that just entered the tail.
   dlra_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .tag            (tag3_ff),
      .acc            (cell_q[MAX_NEURONS-1]),
      .relu_en        (cfg_relu_ff),
      .rsp_valid      (rsp_valid),
      .rsp_out_neuron (rsp_out_neuron),
      .rsp_activation (rsp_activation),
      .rsp_best_index (rsp_best_index),
      .rsp_last       (rsp_last)
   );

   assign busy      = active_ff | pipe_busy | tag3_ff.valid;
   assign csr_ready = 1'b1;

`ifndef SYNTH
   // A feed transfer always occupies the block.
   a_feed_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_FEED)) |=> busy)
      else $error("feed transfer did not raise busy");

   // Results only come out of a pass that was in progress.
   a_rsp_in_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe outside a pass");

   // The argmax field is zero except on the final result.
   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_best_index == '0))
      else $error("best index set before the final result");

   // Nothing follows the final result of a vector directly.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result right after the final result");
`endif

endmodule
